@@ rtl/nnf_pkg.sv @@
// Shared types, status codes and pitch table for the note name to frequency block.
`default_nettype none
package nnf_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Fraction bits of the pitch table entries
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_W    = 34;

  // Parsed note handed from the parser to the frequency stage
  typedef struct packed {
    logic              invalid;
    logic signed [5:0] offset;
    logic              tail_seen;
    logic              oct_neg;
    logic [7:0]        oct_val;
  } nnf_note_t;

  // 440 * 2^(r/12) Hz with 24 fraction bits
  function automatic logic [TABLE_W-1:0] pitch_entry(input logic [3:0] r);
    logic [TABLE_W-1:0] t;
    case (r)
      4'd0:    t = 34'd7381975040;
      4'd1:    t = 34'd7820930118;
      4'd2:    t = 34'd8285986824;
      4'd3:    t = 34'd8778697240;
      4'd4:    t = 34'd9300705743;
      4'd5:    t = 34'd9853754486;
      4'd6:    t = 34'd10439689219;
      4'd7:    t = 34'd11060465444;
      4'd8:    t = 34'd11718154944;
      4'd9:    t = 34'd12414952697;
      4'd10:   t = 34'd13153184201;
      4'd11:   t = 34'd13935313234;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/note_name_to_frequency.sv @@
// Top level of the note name to frequency converter.
//
// Input queue: one character a word on in_char_code, in_last marking the final
// character of a name. A word is taken when push is high and full is low.
// Result queue: one word per name, out_freq_q16 (unsigned, FRAC_BITS fraction
// bits) and out_status (ok, invalid name, semitone out of range). The oldest
// result shows while empty is low; pop takes it.
// Throughput: one character per cycle, sustained while full stays low, names back to back.
// After its last character is taken, a name's note passes from the parser to
// a small queue, then a range-check stage and a table-and-shift stage that
// ends in the output register, where its result shows.
// The parser writes into a QUEUE_DEPTH queue; the back end drains it whenever
// its output register is free, so a stalled receiver first fills the output
// register, then the range-check stage, then the queue, and only then raises
// full. No word is dropped or repeated under stalls.
// Reset (rst_n low, synchronous) empties every stage and returns the parser
// to the leading-whitespace phase; full is held high while reset is applied.
`default_nettype none
module note_name_to_frequency import nnf_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_freq_q16,
  output logic [1:0]       out_status
);

  logic      accept;
  logic      note_push, note_pop, q_full, q_empty;
  nnf_note_t note_in, note_out;
  logic      res_valid;

  assign full   = q_full || !rst_n;
  assign accept = push && !full;

  // Front: parse one character per cycle while accept is high, emit a note on the last one
  nnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .last      (in_last),
    .note_push (note_push),
    .note      (note_in)
  );

  // Queue between parser and frequency stage
  nnf_fifo #(
    .WIDTH ($bits(nnf_note_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (note_push),
    .wr_data (note_in),
    .full    (q_full),
    .rd_en   (note_pop),
    .rd_data (note_out),
    .empty   (q_empty)
  );

  // Back: semitone number, range check, table lookup and shift
  nnf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .note_valid (!q_empty),
    .note       (note_out),
    .note_pop   (note_pop),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_freq   (out_freq_q16),
    .res_status (out_status)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

@@ rtl/nnf_fifo.sv @@
// Small register queue between the parser and the frequency stage.
`default_nettype none
module nnf_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  // DEPTH must be a power of two so the pointers wrap on their own (not enforced)
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nnf_front.sv @@
// Character parser: letter, accidentals and atoi-style octave, one word per name.
`default_nettype none
module nnf_front import nnf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  output logic            note_push,
  output nnf_note_t       note
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_ACC, PH_TWS, PH_SIGN, PH_DIG, PH_DONE
  } phase_t;

  phase_t            phase_r, phase_nxt, tph;
  logic signed [5:0] off_r, off_nxt;
  logic [7:0]        oct_r, oct_nxt;
  logic              neg_r, neg_nxt;
  logic              tail_r, tail_nxt;
  logic              inv_r, inv_nxt;
  logic              do_tail, is_ws, is_dig;
  logic [7:0]        lc;
  logic [6:0]        letter;
  logic [11:0]       dig_sum;

  // {valid, semitones from A}
  function automatic logic [6:0] letter_code(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "c":     r = {1'b1, -6'sd9};
      "d":     r = {1'b1, -6'sd7};
      "e":     r = {1'b1, -6'sd5};
      "f":     r = {1'b1, -6'sd4};
      "g":     r = {1'b1, -6'sd2};
      "a":     r = {1'b1, 6'sd0};
      "b":     r = {1'b1, 6'sd2};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign lc      = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;
  assign is_ws   = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
  assign is_dig  = (char_code >= "0" && char_code <= "9");
  assign letter  = letter_code(lc);
  assign dig_sum = ({4'b0, oct_r} << 3) + ({4'b0, oct_r} << 1) + {8'b0, char_code[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    oct_nxt   = oct_r;
    neg_nxt   = neg_r;
    tail_nxt  = tail_r;
    inv_nxt   = inv_r;
    do_tail   = 1'b0;
    tph       = phase_r;
    case (phase_r)
      PH_LEAD: begin
        if (!is_ws) begin
          if (letter[6]) begin
            off_nxt   = letter[5:0];
            phase_nxt = PH_ACC;
          end else begin
            inv_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_ACC: begin
        if (lc == "b") begin
          if (off_r != -6'sd32) off_nxt = off_r - 6'sd1;
        end else if (char_code == "#") begin
          if (off_r != 6'sd31) off_nxt = off_r + 6'sd1;
        end else begin
          tail_nxt = 1'b1;
          do_tail  = 1'b1;
          tph      = PH_TWS;
        end
      end
      default: do_tail = 1'b1;
    endcase

    if (do_tail) begin
      case (tph)
        PH_TWS: begin
          if (is_ws) begin
            phase_nxt = PH_TWS;
          end else if (char_code == "+" || char_code == "-") begin
            neg_nxt   = (char_code == "-");
            phase_nxt = PH_SIGN;
          end else if (is_dig) begin
            oct_nxt   = (dig_sum > 12'd255) ? 8'd255 : dig_sum[7:0];
            phase_nxt = PH_DIG;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_SIGN, PH_DIG: begin
          if (is_dig) begin
            oct_nxt   = (dig_sum > 12'd255) ? 8'd255 : dig_sum[7:0];
            phase_nxt = PH_DIG;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  assign note_push      = accept && last;
  assign note.invalid   = inv_nxt || (phase_nxt == PH_LEAD);
  assign note.offset    = off_nxt;
  assign note.tail_seen = tail_nxt;
  assign note.oct_neg   = neg_nxt;
  assign note.oct_val   = oct_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      phase_r <= PH_LEAD;
      off_r   <= '0;
      oct_r   <= '0;
      neg_r   <= 1'b0;
      tail_r  <= 1'b0;
      inv_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      oct_r   <= oct_nxt;
      neg_r   <= neg_nxt;
      tail_r  <= tail_nxt;
      inv_r   <= inv_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nnf_back.sv @@
// Frequency stage: semitone number and range check, then table lookup and shift.
`default_nettype none
module nnf_back import nnf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        note_valid,
  input  wire nnf_note_t   note,
  output logic             note_pop,
  output logic             res_valid,
  input  wire logic        res_pop,
  output logic [31:0]      res_freq,
  output logic [1:0]       res_status
);
  // Extra left room so the shift is always rightward
  localparam int LSH = (FRAC_BITS > 17) ? FRAC_BITS - 17 : 0;
  localparam int WW  = TABLE_W + LSH;
  localparam int SA0 = 32 - FRAC_BITS + LSH;

  logic              s1_valid_r;
  logic [1:0]        s1_status_r;
  logic [7:0]        s1_nn_r;
  logic              out_valid_r;
  logic [31:0]       out_freq_r;
  logic [1:0]        out_status_r;
  logic              out_adv, s1_adv;

  logic signed [9:0]  oct;
  logic signed [13:0] om4, n;
  logic [1:0]         st1;
  logic [15:0]        prod;
  logic [3:0]         q, r;
  logic [5:0]         sa;
  logic [WW-1:0]      wide, shifted;
  logic [31:0]        freq;

  assign out_adv  = !out_valid_r || res_pop;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign note_pop = note_valid && s1_adv;

  // n = offset + 12 * (octave - 4)
  always_comb begin
    if (!note.tail_seen) oct = 10'sd4;
    else if (note.oct_neg) oct = -$signed({2'b00, note.oct_val});
    else oct = $signed({2'b00, note.oct_val});
    om4 = 14'(oct - 10'sd4);
    n   = 14'(note.offset) + (om4 <<< 3) + (om4 <<< 2);
    if (note.invalid) st1 = ST_INVALID;
    else if (n < -14'sd96 || n > 14'sd86) st1 = ST_RANGE;
    else st1 = ST_OK;
  end

  // nn / 12 by reciprocal, exact for nn below 192
  always_comb begin
    prod    = {8'b0, s1_nn_r} * 16'd171;
    q       = prod[14:11];
    r       = 4'(s1_nn_r - ({4'b0, q} << 3) - ({4'b0, q} << 2));
    sa      = 6'(SA0) - {2'b0, q};
    wide    = WW'(pitch_entry(r)) << LSH;
    shifted = wide >> sa;
    if (|shifted[WW-1:32]) freq = 32'hFFFF_FFFF;
    else freq = shifted[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= note_valid;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (note_pop) begin
      s1_status_r <= st1;
      s1_nn_r     <= 8'(n + 14'sd96);
    end
    if (out_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_freq_r   <= (s1_status_r == ST_OK) ? freq : 32'd0;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_freq   = out_freq_r;
  assign res_status = out_status_r;

endmodule
`default_nettype wire

@@ rtl/nnf_checker.sv @@
// Port-level checks for the note name to frequency converter, bound to the top.
`default_nettype none
module nnf_checker import nnf_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] out_freq_q16,
  input wire logic [1:0]  out_status
);

  // Reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // No input word is taken while reset is applied
  a_full_reset: assert property (@(posedge clk) !rst_n |-> full)
    else $error("full low during reset");

  // Status code is one of the three defined values
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == ST_OK || out_status == ST_INVALID ||
                out_status == ST_RANGE))
    else $error("undefined status code");

  // A failing status carries a zero frequency
  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> (out_freq_q16 == 32'd0))
    else $error("nonzero frequency with failing status");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_freq_q16) && $stable(out_status)))
    else $error("result word changed while stalled");

endmodule

bind note_name_to_frequency nnf_checker u_nnf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .out_freq_q16 (out_freq_q16),
  .out_status   (out_status)
);
`default_nettype wire

@@ tb/sv/tb_note_name_to_frequency.sv @@
// Self-checking testbench for the note name to frequency converter.
module tb_note_name_to_frequency;
  import nnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_WORDS = 1750;

  // One expected result word
  typedef struct packed {
    logic [31:0] freq;
    logic [1:0]  status;
  } tone_t;

  // Scoreboard: tracks the parser state for every accepted character word and
  // queues the tone that a name should produce when its last word goes in.
  class pitch_scoreboard;
    typedef enum int {PH_LEAD, PH_ACC, PH_TAIL_WS, PH_SIGN, PH_DIGITS, PH_DONE} phase_e;

    phase_e phase;
    int     offset;
    int     oct_val;
    bit     oct_neg;
    bit     tail_seen;
    bit     invalid;
    tone_t  expected_tones[$];
    int     errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase     = PH_LEAD;
      offset    = 0;
      oct_val   = 0;
      oct_neg   = 1'b0;
      tail_seen = 1'b0;
      invalid   = 1'b0;
    endfunction

    static function bit is_space(byte unsigned c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    static function byte unsigned lower(byte unsigned c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function void add_digit(byte unsigned c);
      int v;
      v = oct_val * 10 + int'(c - 8'd48);
      oct_val = (v > 255) ? 255 : v;
      phase = PH_DIGITS;
    endfunction

    // atoi-style octave reader: spaces, one sign, digits, then ignore the rest
    function void tail_step(byte unsigned c);
      bit digit;
      digit = (c >= "0" && c <= "9");
      case (phase)
        PH_TAIL_WS: begin
          if (!is_space(c)) begin
            if (c == "+" || c == "-") begin
              oct_neg = (c == "-");
              phase = PH_SIGN;
            end else if (digit) begin
              add_digit(c);
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (digit) add_digit(c);
          else phase = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    function void note_word(byte unsigned c, bit last);
      int          oct;
      int          n;
      int          nn;
      int          k;
      int          sh;
      longint unsigned t;
      longint unsigned v;
      tone_t       tone;

      case (phase)
        PH_LEAD: begin
          if (!is_space(c)) begin
            phase = PH_ACC;
            case (lower(c))
              "c": offset = -9;
              "d": offset = -7;
              "e": offset = -5;
              "f": offset = -4;
              "g": offset = -2;
              "a": offset = 0;
              "b": offset = 2;
              default: begin
                invalid = 1'b1;
                phase = PH_DONE;
              end
            endcase
          end
        end
        PH_ACC: begin
          if (lower(c) == "b") begin
            if (offset > -32) offset--;
          end else if (c == "#") begin
            if (offset < 31) offset++;
          end else begin
            tail_seen = 1'b1;
            phase = PH_TAIL_WS;
            tail_step(c);
          end
        end
        default: tail_step(c);
      endcase

      if (!last) return;

      tone.freq = '0;
      tone.status = ST_OK;
      if (invalid || phase == PH_LEAD) begin
        tone.status = ST_INVALID;
      end else begin
        oct = 4;
        if (tail_seen) oct = oct_neg ? -oct_val : oct_val;
        n = offset + 12 * (oct - 4);
        if (n < -96 || n > 86) begin
          tone.status = ST_RANGE;
        end else begin
          nn = n + 96;
          k  = nn / 12 - 8;
          sh = TABLE_FRAC - FRAC_BITS - k;
          // 440 * 2^(r/12) with 24 fraction bits
          case (nn % 12)
            0:  t = 64'd7381975040;
            1:  t = 64'd7820930118;
            2:  t = 64'd8285986824;
            3:  t = 64'd8778697240;
            4:  t = 64'd9300705743;
            5:  t = 64'd9853754486;
            6:  t = 64'd10439689219;
            7:  t = 64'd11060465444;
            8:  t = 64'd11718154944;
            9:  t = 64'd12414952697;
            10: t = 64'd13153184201;
            default: t = 64'd13935313234;
          endcase
          v = (sh >= 0) ? (t >> sh) : (t << (-sh));
          tone.freq = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
      end
      expected_tones.push_back(tone);
      clear();
    endfunction

    function void check_result(logic [31:0] freq, logic [1:0] status);
      tone_t exp_tone;
      if (expected_tones.size() == 0) begin
        $display("%0t: unexpected result freq %h status %0d", $time, freq, status);
        errors++;
        return;
      end
      exp_tone = expected_tones.pop_front();
      if (status !== exp_tone.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_tone.status, status);
        errors++;
      end
      if (freq !== exp_tone.freq) begin
        $display("%0t: freq mismatch, expected %h, actual %h", $time, exp_tone.freq, freq);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_char_code = '0;
  logic        in_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_freq_q16;
  logic [1:0]  out_status;

  pitch_scoreboard sb;
  byte unsigned    name_buf[$];
  // burst flags: while set, that side never idles
  bit              send_burst = 1'b0;
  bit              recv_burst = 1'b0;

  note_name_to_frequency #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_freq_q16 (out_freq_q16),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Drive one character word. Called at a falling edge; returns at the falling
  // edge after the word was taken. push is only lowered when a gap is drawn,
  // so back-to-back words never see two assignments to push in one step.
  task automatic send_word(input byte unsigned c, input bit last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    in_char_code <= c;
    in_last      <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(c, last);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  // Receiver: random pop gaps, one result word checked per handshake.
  task automatic drain_results();
    int gap;
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result(out_freq_q16, out_status);
      @(negedge clk);
    end
  endtask

  function automatic byte unsigned space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  // Build one random name in name_buf. Mostly well-formed names with random
  // content; the rest is raw noise, blank names and bad first letters.
  task automatic make_name();
    int kind;
    int r;
    byte unsigned acc;
    name_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 17) begin
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4)) name_buf.push_back(space_char());
      end else begin
        // not a note letter: h..z in either case
        acc = 8'("h" + $urandom_range(0, 18));
        if ($urandom_range(0, 1) == 1) acc = acc - 8'd32;
        name_buf.push_back(acc);
        repeat ($urandom_range(0, 3)) name_buf.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) name_buf.push_back(space_char());
      acc = 8'("a" + $urandom_range(0, 6));
      if ($urandom_range(0, 1) == 1) acc = acc - 8'd32;
      name_buf.push_back(acc);
      // accidentals; now and then a long run to hit saturation
      if ($urandom_range(0, 49) == 0) begin
        acc = ($urandom_range(0, 1) == 1) ? "#" : "b";
        repeat ($urandom_range(30, 40)) name_buf.push_back(acc);
      end else begin
        repeat ($urandom_range(0, 2)) begin
          r = $urandom_range(0, 2);
          name_buf.push_back(r == 0 ? "b" : (r == 1 ? "B" : "#"));
        end
      end
      r = $urandom_range(0, 9);
      if (r == 2) begin
        // tail with no number
        name_buf.push_back(8'("h" + $urandom_range(0, 18)));
      end else if (r > 2) begin
        if ($urandom_range(0, 9) == 0) name_buf.push_back(space_char());
        r = $urandom_range(0, 9);
        if (r < 2) name_buf.push_back("-");
        else if (r == 2) name_buf.push_back("+");
        r = $urandom_range(0, 99);
        repeat (r < 3 ? 4 : (r < 13 ? $urandom_range(2, 3) : 1))
          name_buf.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 2)) name_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int sent;
    sb = new();
    sent = 0;

    // synchronous reset, released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    fork
      drain_results();
    join_none

    // Directed names
    send_text("A");                                    // plain letter, no tail
    send_word(8'd9, 1'b0); send_word(8'd13, 1'b0);     // leading whitespace
    send_text("G");
    send_text("Z");                                    // bad letter
    send_word(8'd32, 1'b0); send_word(8'd11, 1'b1);    // blank name
    send_text("C#x");                                  // tail without digits
    send_text("d-1q");                                 // negative octave, trailing junk
    send_text("b999");                                 // long octave, out of range
    send_word(8'h00, 1'b1);                            // NUL as first character
    send_word("a", 1'b0); send_word(8'hFF, 1'b1);      // high code in the tail
    send_text("A-4");                                  // lowest semitone in range
    send_text("b11");                                  // highest semitone in range

    // Random names
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
      make_name();
      foreach (name_buf[i]) send_word(name_buf[i], i == name_buf.size() - 1);
      sent += name_buf.size();
    end
    push <= 1'b0;

    // drain, then let the back end settle
    while (sb.expected_tones.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/nnf_pkg.sv
rtl/nnf_fifo.sv
rtl/nnf_front.sv
rtl/nnf_back.sv
rtl/note_name_to_frequency.sv
rtl/nnf_checker.sv
tb/sv/tb_note_name_to_frequency.sv
